FILE: rtl/core/sgm_pkg.sv
// ----------------------------------------------------------------------------
// Sobel gradient magnitude package
// Types and constants shared by the front end, back end and top level.
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned COL_W = 11;
  localparam int unsigned ROW_W = COL_W + 1;
  localparam int unsigned MAG_W = 11;
  localparam int unsigned CFG_W = 11;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE    = 2'd2;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel_value;
  } sgm_in_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             last_of_frame;
  } sgm_out_t;

  // One classified request passed from the front end to the back end.
  typedef struct packed {
    logic             is_pixel;
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    logic             row_ge1;
    logic             row_ge2;
    logic             col_zero;
    logic             left_ok;
    logic             emit;
    logic             last;
  } sgm_item_t;

endpackage

FILE: rtl/core/sgm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sgm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sgm_front.sv
// ----------------------------------------------------------------------------
// Sobel front end
// Accepts requests, tracks the raster position and queues classified work.
// ----------------------------------------------------------------------------
module sgm_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic [sgm_pkg::COL_W-1:0] width_i,
  input  logic [sgm_pkg::COL_W-1:0] height_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  sgm_pkg::sgm_in_t          in_data_i,
  output logic                      q_valid_o,
  output sgm_pkg::sgm_item_t        q_item_o,
  input  logic                      q_pop_i
);

  logic [sgm_pkg::COL_W-1:0] col_q, col_d, col_c, col_inc;
  logic [sgm_pkg::ROW_W-1:0] row_q, row_d, h_ext;
  logic                      accept, ignore, push, is_pixel, emit, last;
  sgm_pkg::sgm_item_t        item;
  sgm_pkg::sgm_item_t        fifo_q [2];
  logic [1:0]                count_q, count_d;
  logic                      wr_ptr_q, rd_ptr_q;

  assign h_ext    = {1'b0, height_i};
  assign is_pixel = row_q < h_ext;
  assign ignore   = is_pixel && (in_data_i.op == sgm_pkg::OP_FLUSH);
  assign col_c    = (col_q >= width_i) ? '0 : col_q;
  assign emit     = (row_q >= sgm_pkg::ROW_W'(2)) ||
                    ((row_q == sgm_pkg::ROW_W'(1)) && (col_c != '0));
  assign last     = (row_q == h_ext + sgm_pkg::ROW_W'(1)) && (col_c == '0);
  assign col_inc  = col_c + sgm_pkg::COL_W'(1);

  assign in_stall_o = (count_q == 2'd2);
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && !ignore;

  always_comb begin
    item.is_pixel = is_pixel;
    item.pixel    = in_data_i.pixel_value;
    item.col      = col_c;
    item.row_ge1  = row_q >= sgm_pkg::ROW_W'(1);
    item.row_ge2  = row_q >= sgm_pkg::ROW_W'(2);
    item.col_zero = col_c == '0;
    item.left_ok  = (col_c == '0) ? (width_i >= sgm_pkg::COL_W'(2))
                                  : (col_c >= sgm_pkg::COL_W'(2));
    item.emit     = emit;
    item.last     = last;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (clear_i) begin
      col_d = '0;
      row_d = '0;
    end else if (push) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= width_i) begin
        col_d = '0;
        row_d = row_q + sgm_pkg::ROW_W'(1);
      end else begin
        col_d = col_inc;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (push && !q_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

  assign q_valid_o = count_q != 2'd0;
  assign q_item_o  = fifo_q[rd_ptr_q];

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> (count_q != 2'd0))
    else $error("queue popped while empty");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) |=> (count_q != 2'd3))
    else $error("queue count overran its depth");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) |-> !push)
    else $error("request queued while the queue was full");

endmodule

FILE: rtl/core/sgm_back.sv
// ----------------------------------------------------------------------------
// Sobel back end
// Line stores, 3x3 window, kernels, bit-serial square root and output stage.
// ----------------------------------------------------------------------------
module sgm_back #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               edge_mode_i,
  input  logic               q_valid_i,
  input  sgm_pkg::sgm_item_t q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sgm_pkg::sgm_out_t  out_data_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = sgm_pkg::PIX_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_SQUARE = 3'd2;
  localparam logic [2:0] ST_ROOT   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]         state_q, state_d;
  sgm_pkg::sgm_item_t item_q;
  logic [PW-1:0]      win_q [3][3];
  logic [PW-1:0]      up_rd, mid_rd, mid_raw, top_raw, fill, top_px, bot_px, bot_raw;
  logic [PW-1:0]      lft [3];
  logic [PW-1:0]      ctr [3];
  logic [PW-1:0]      rgt [3];
  logic [PW-1:0]      newc [3];
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [11:0]        sx_pos, sx_neg, sy_pos, sy_neg;
  logic signed [11:0] gx_q, gy_q;
  logic signed [23:0] sqx, sqy;
  logic [21:0]        sum_q, rad_q;
  logic [13:0]        rem_q, rem_sh, rem_sub;
  logic [13:0]        trial;
  logic [10:0]        root_q;
  logic [3:0]         cnt_q;
  logic               last_q, out_valid_q, load_out;
  sgm_pkg::sgm_out_t  out_q;

  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;
  assign ram_we    = state_q == ST_READ;
  assign ram_waddr = AW'(item_q.col);

  sgm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(mid_raw),
    .raddr_i(AW'(q_item_i.col)),
    .rdata_o(up_rd)
  );

  sgm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_middle (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(bot_raw),
    .raddr_i(AW'(q_item_i.col)),
    .rdata_o(mid_rd)
  );

  // New column entering the window; rows outside the frame take the fill value.
  assign mid_raw = item_q.row_ge1 ? mid_rd : '0;
  assign top_raw = item_q.row_ge2 ? up_rd : '0;
  assign fill    = edge_mode_i ? mid_raw : '0;
  assign top_px  = item_q.row_ge2 ? top_raw : fill;
  assign bot_raw = item_q.is_pixel ? item_q.pixel : '0;
  assign bot_px  = item_q.is_pixel ? bot_raw : fill;
  assign newc[0] = top_px;
  assign newc[1] = mid_raw;
  assign newc[2] = bot_px;

  // The centre column is always the newest one held before the shift.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ctr[r] = win_q[2][r];
      lft[r] = item_q.left_ok ? win_q[1][r] : (edge_mode_i ? win_q[2][r] : '0);
      rgt[r] = item_q.col_zero ? (edge_mode_i ? win_q[2][r] : '0) : newc[r];
    end
  end

  assign sx_pos = 12'(rgt[0]) + {3'd0, rgt[1], 1'b0} + 12'(rgt[2]);
  assign sx_neg = 12'(lft[0]) + {3'd0, lft[1], 1'b0} + 12'(lft[2]);
  assign sy_pos = 12'(lft[2]) + {3'd0, ctr[2], 1'b0} + 12'(rgt[2]);
  assign sy_neg = 12'(lft[0]) + {3'd0, ctr[0], 1'b0} + 12'(rgt[0]);

  assign sqx = gx_q * gx_q;
  assign sqy = gy_q * gy_q;

  // One result bit per cycle of the restoring square root.
  assign rem_sh  = {rem_q[11:0], rad_q[21:20]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign rem_sub = rem_sh - trial;

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (q_valid_i) state_d = ST_READ;
      ST_READ:   state_d = item_q.emit ? ST_SQUARE : ST_IDLE;
      ST_SQUARE: state_d = ST_ROOT;
      ST_ROOT:   if (cnt_q == 4'd10) state_d = ST_DONE;
      ST_DONE:   if (load_out) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int s = 0; s < 3; s++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[s][r] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_READ) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= newc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    if (state_q == ST_READ) begin
      gx_q   <= $signed(sx_pos - sx_neg);
      gy_q   <= $signed(sy_pos - sy_neg);
      last_q <= item_q.last;
    end
    if (state_q == ST_SQUARE) begin
      sum_q  <= 22'(sqx) + 22'(sqy);
      rad_q  <= 22'(sqx) + 22'(sqy);
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
    end
    if (state_q == ST_ROOT) begin
      rad_q <= {rad_q[19:0], 2'b00};
      cnt_q <= cnt_q + 4'd1;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sub;
        root_q <= {root_q[9:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[9:0], 1'b0};
      end
    end
    if (load_out) begin
      out_q.magnitude     <= root_q;
      out_q.last_of_frame <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_root_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |->
      ((23'(root_q) * 23'(root_q) <= 23'(sum_q)) &&
       ((23'(root_q) + 23'd1) * (23'(root_q) + 23'd1) > 23'(sum_q))))
    else $error("square root out of bounds");

  a_load_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("output loaded outside the done state");

  a_pop_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == ST_READ))
    else $error("popped request not read");

endmodule

FILE: rtl/core/sobel_gradient_magnitude_unit.sv
// ----------------------------------------------------------------------------
// Sobel gradient magnitude unit
// Streaming 3x3 Sobel edge detector returning floor(sqrt(gx^2 + gy^2)).
// ----------------------------------------------------------------------------
// Usage: pixels enter in raster order on the input channel (valid/stall),
// one request per pixel with op set to pixel. After the last pixel of a
// frame, width + 1 flush requests push out the remaining results; a flush
// request arriving while pixels are still expected is accepted and dropped.
// Each result leaves on the output channel with last_of_frame set on the
// final result of the frame, after which the raster counters restart.
// Results lag the inputs by one row plus one pixel in request count.
// Each request that produces a result occupies the back end for a line-store
// read, a write-back and kernel step, a squaring step, the bit-serial square
// root and a hand-off step, in that order. A request that produces no result
// ends after the write-back and kernel step. The square root sets
// the rate. A two-entry queue separates the front and back ends, so input
// requests are taken while the back end is busy until that queue fills.
// Reset clears counters, window and queue and loads the default frame size;
// the line stores are not cleared, as the border logic never reads a stale
// entry. While the receiver stalls, the result register holds its value and
// the back end waits with the next result finished.
// Write configuration only while the unit is idle; the unit does not check.
// Writing the frame width or height abandons any frame in progress.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sgm_pkg::sgm_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sgm_pkg::sgm_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sgm_pkg::CFG_W-1:0]     cfg_wdata_i
);

  // Sizes above the maximum are clamped; zero is taken as one.
  localparam int unsigned RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int unsigned RST_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  logic [sgm_pkg::COL_W-1:0] width_q, width_d, height_q, height_d;
  logic                      edge_mode_q, edge_mode_d;
  logic                      clear;
  logic                      q_valid, q_pop;
  sgm_pkg::sgm_item_t        q_item;

  always_comb begin
    width_d     = width_q;
    height_d    = height_q;
    edge_mode_d = edge_mode_q;
    clear       = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        sgm_pkg::CFG_FRAME_WIDTH: begin
          clear = 1'b1;
          if (cfg_wdata_i == '0) begin
            width_d = sgm_pkg::COL_W'(1);
          end else if (32'(cfg_wdata_i) > MAX_WIDTH) begin
            width_d = sgm_pkg::COL_W'(MAX_WIDTH);
          end else begin
            width_d = cfg_wdata_i;
          end
        end
        sgm_pkg::CFG_FRAME_HEIGHT: begin
          clear = 1'b1;
          if (cfg_wdata_i == '0) begin
            height_d = sgm_pkg::COL_W'(1);
          end else if (32'(cfg_wdata_i) > MAX_HEIGHT) begin
            height_d = sgm_pkg::COL_W'(MAX_HEIGHT);
          end else begin
            height_d = cfg_wdata_i;
          end
        end
        sgm_pkg::CFG_EDGE_MODE: begin
          edge_mode_d = cfg_wdata_i[0];
        end
        default: begin
          clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= sgm_pkg::COL_W'(RST_W);
      height_q    <= sgm_pkg::COL_W'(RST_H);
      edge_mode_q <= 1'b1;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      edge_mode_q <= edge_mode_d;
    end
  end

  sgm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clear),
    .width_i   (width_q),
    .height_i  (height_q),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  sgm_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .edge_mode_i(edge_mode_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Sobel gradient magnitude unit testbench
// Streams small grayscale frames and a few cut-short frames at the size limits
// through the unit, predicts every gradient magnitude in step with each
// accepted request and checks the results in order while both sides idle.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles allowed for a request that yields nothing to drain the back end.
  localparam int DRAIN_CYCLES = 40;
  // Cycles with no request or result taken, while work is pending, before giving up.
  localparam int STALL_LIMIT  = 5000;
  localparam int LONG_HOLD    = 400;
  localparam int LINE_DEPTH   = 1024;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  sgm_pkg::sgm_in_t              in_data_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  sgm_pkg::sgm_out_t             out_data_o;
  logic                          cfg_we_i;
  logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [sgm_pkg::CFG_W-1:0]     cfg_wdata_i;

  sobel_gradient_magnitude_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Requests waiting to be offered, and results the predictor has produced.
  sgm_pkg::sgm_in_t  pixel_queue[$];
  sgm_pkg::sgm_out_t magnitude_queue[$];

  // Percentages of cycles in which each side idles; set only while quiet.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_go = 0;
  int          hold_left = 0;

  int unsigned requests_taken = 0;
  int unsigned results_checked = 0;
  int unsigned frames_sent = 0;
  int unsigned errors = 0;
  int          quiet_cycles = 0;

  // Predictor state: frame geometry, line stores, window and raster counters.
  int unsigned    p_width, p_height;
  bit             p_edge_rep;
  logic [sgm_pkg::PIX_W-1:0] p_upper[LINE_DEPTH];
  logic [sgm_pkg::PIX_W-1:0] p_middle[LINE_DEPTH];
  // Column slot s (0 is the oldest) and row r (0 is the top) live at s*3 + r.
  logic [sgm_pkg::PIX_W-1:0] p_win[9];
  int unsigned    p_col, p_row, p_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_size(logic [sgm_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > LINE_DEPTH) return LINE_DEPTH;
    return 32'(v);
  endfunction

  function automatic int unsigned int_sqrt(int unsigned v);
    int unsigned r;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      if ((r | (1 << b)) * (r | (1 << b)) <= v) r = r | (1 << b);
    end
    return r;
  endfunction

  // Gradient magnitude around the centre column held in window slot cs.
  function automatic int unsigned gradient_at(int cs, bit left_ok, bit right_ok);
    int n[9];
    int gx, gy, ctr, fill;
    int unsigned m;
    for (int r = 0; r < 3; r++) begin
      ctr = int'(p_win[cs*3 + r]);
      fill = p_edge_rep ? ctr : 0;
      n[r*3 + 0] = left_ok ? int'(p_win[(cs-1)*3 + r]) : fill;
      n[r*3 + 1] = ctr;
      n[r*3 + 2] = right_ok ? int'(p_win[(cs+1)*3 + r]) : fill;
    end
    gx = -n[0] + n[2] - 2*n[3] + 2*n[5] - n[6] + n[8];
    gy = -n[0] - 2*n[1] - n[2] + n[6] + 2*n[7] + n[8];
    m = int_sqrt(gx*gx + gy*gy);
    return (m > 2047) ? 2047 : m;
  endfunction

  function automatic void shift_window(logic [sgm_pkg::PIX_W-1:0] t,
                                       logic [sgm_pkg::PIX_W-1:0] m,
                                       logic [sgm_pkg::PIX_W-1:0] b);
    for (int i = 0; i < 6; i++) p_win[i] = p_win[i+3];
    p_win[6] = t;
    p_win[7] = m;
    p_win[8] = b;
  endfunction

  function automatic void predict_magnitude(sgm_pkg::sgm_in_t req);
    bit is_pix, emit, last;
    int unsigned c, pos, mag;
    logic [sgm_pkg::PIX_W-1:0] bot_raw, mid_raw, top_raw, fill, top, bot;
    sgm_pkg::sgm_out_t res;
    is_pix = p_row < p_height;
    // A flush while pixels are still expected is dropped outright.
    if (is_pix && req.op == sgm_pkg::OP_FLUSH) return;
    c = (p_col >= p_width) ? 0 : p_col;
    bot_raw = is_pix ? req.pixel_value : '0;
    mid_raw = (p_row >= 1) ? p_middle[c] : '0;
    top_raw = (p_row >= 2) ? p_upper[c] : '0;
    fill = p_edge_rep ? mid_raw : '0;
    top = (p_row >= 2) ? top_raw : fill;
    bot = is_pix ? bot_raw : fill;
    pos = p_row * p_width + c;
    emit = pos >= p_width + 1;
    mag = 0;
    if (c == 0) begin
      // The centre is the last column of the previous row.
      if (emit) mag = gradient_at(2, p_width >= 2, 1'b0);
      shift_window(top, mid_raw, bot);
    end else begin
      shift_window(top, mid_raw, bot);
      if (emit) mag = gradient_at(1, c >= 2, 1'b1);
    end
    p_upper[c] = mid_raw;
    p_middle[c] = bot_raw;
    c++;
    if (c >= p_width) begin
      c = 0;
      p_row++;
    end
    p_col = c;
    if (!emit) return;
    last = p_count + 1 >= p_width * p_height;
    res.magnitude = mag[sgm_pkg::MAG_W-1:0];
    res.last_of_frame = last;
    magnitude_queue = {magnitude_queue, res};
    p_count++;
    if (last) begin
      p_col = 0;
      p_row = 0;
      p_count = 0;
    end
  endfunction

  // Sender: holds a stalled request, otherwise offers the next one or idles.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_magnitude(in_data_i);
        requests_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pixel_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off counted here once requested.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (magnitude_queue.size() == 0) begin
          $error("result with no expectation: magnitude %0d last_of_frame %0d",
                 out_data_o.magnitude, out_data_o.last_of_frame);
          errors++;
        end else begin
          sgm_pkg::sgm_out_t e;
          e = magnitude_queue.pop_front();
          if (out_data_o.magnitude !== e.magnitude) begin
            $error("magnitude: expected %0d, actual %0d", e.magnitude,
                   out_data_o.magnitude);
            errors++;
          end
          if (out_data_o.last_of_frame !== e.last_of_frame) begin
            $error("last_of_frame: expected %0d, actual %0d", e.last_of_frame,
                   out_data_o.last_of_frame);
            errors++;
          end
          results_checked++;
        end
      end
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: only counts while work is outstanding and nothing moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (pixel_queue.size() > 0 || magnitude_queue.size() > 0 ||
                   in_valid_i) begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("** sobel_gradient_magnitude_unit: FAILED **");
          $finish;
        end
      end
    end
  end

  // Waits until every request has gone in and every result has come out.
  task automatic settle();
    while (pixel_queue.size() > 0 || in_valid_i || magnitude_queue.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sgm_pkg::CFG_IDX_W-1:0] idx,
                           logic [sgm_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx == sgm_pkg::CFG_EDGE_MODE) begin
      p_edge_rep = val[0];
    end else begin
      if (idx == sgm_pkg::CFG_FRAME_WIDTH) p_width = clamp_size(val);
      else p_height = clamp_size(val);
      p_col = 0;
      p_row = 0;
      p_count = 0;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Settles, then loads the idling mix, a new frame geometry and the border mode.
  task automatic setup(int unsigned w, int unsigned h, bit em,
                       int unsigned s_idle, int unsigned r_idle);
    settle();
    @(negedge clk_i);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    write_reg(sgm_pkg::CFG_FRAME_WIDTH, sgm_pkg::CFG_W'(w));
    write_reg(sgm_pkg::CFG_FRAME_HEIGHT, sgm_pkg::CFG_W'(h));
    write_reg(sgm_pkg::CFG_EDGE_MODE, {{(sgm_pkg::CFG_W-1){1'b0}}, em});
  endtask

  function automatic logic [sgm_pkg::PIX_W-1:0] pick_pixel();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return sgm_pkg::PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic push_req(logic op, logic [sgm_pkg::PIX_W-1:0] v);
    sgm_pkg::sgm_in_t r;
    r.op = op;
    r.pixel_value = v;
    pixel_queue = {pixel_queue, r};
  endtask

  // One frame of pixels and its flush requests; noise adds stray flushes
  // inside the frame and pixel requests among the flushes.
  task automatic push_frame(int unsigned w, int unsigned h, bit noise);
    for (int unsigned i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(9) == 0) push_req(sgm_pkg::OP_FLUSH, pick_pixel());
      push_req(sgm_pkg::OP_PIXEL, pick_pixel());
    end
    for (int unsigned i = 0; i <= w; i++)
      push_req((noise && $urandom_range(3) == 0) ? sgm_pkg::OP_PIXEL : sgm_pkg::OP_FLUSH,
               pick_pixel());
    frames_sent++;
  endtask

  initial begin
    int unsigned w, h, stretch;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    p_width = 1024;
    p_height = 1024;
    p_edge_rep = 1'b1;
    p_col = 0;
    p_row = 0;
    p_count = 0;
    for (int i = 0; i < 9; i++) p_win[i] = '0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      p_upper[i] = '0;
      p_middle[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a 3x3 frame of full-scale steps with replicated borders, a
    // stray flush inside the frame and a pixel among the flushes.
    setup(3, 3, 1'b1, 0, 0);
    push_req(sgm_pkg::OP_PIXEL, 8'd0);
    push_req(sgm_pkg::OP_PIXEL, 8'd255);
    push_req(sgm_pkg::OP_PIXEL, 8'd0);
    push_req(sgm_pkg::OP_FLUSH, 8'd77);
    push_req(sgm_pkg::OP_PIXEL, 8'd255);
    push_req(sgm_pkg::OP_PIXEL, 8'd255);
    push_req(sgm_pkg::OP_PIXEL, 8'd0);
    push_req(sgm_pkg::OP_PIXEL, 8'd0);
    push_req(sgm_pkg::OP_PIXEL, 8'd0);
    push_req(sgm_pkg::OP_PIXEL, 8'd255);
    push_req(sgm_pkg::OP_FLUSH, 8'd0);
    push_req(sgm_pkg::OP_PIXEL, 8'd255);
    push_req(sgm_pkg::OP_FLUSH, 8'd0);
    push_req(sgm_pkg::OP_FLUSH, 8'd0);
    frames_sent++;
    setup(3, 3, 1'b0, 0, 0);
    push_frame(3, 3, 1'b0);
    // Sizes of zero are taken as one pixel.
    setup(0, 0, 1'b0, 0, 0);
    push_frame(1, 1, 1'b0);

    // Sizes beyond the maximum are clamped; these frames are cut short by the
    // next size write, the tall one still producing results on the way.
    setup(2047, 1, 1'b1, 0, 0);
    for (int i = 0; i < 40; i++) push_req(sgm_pkg::OP_PIXEL, pick_pixel());
    setup(1, 2047, 1'b0, 31, 31);
    for (int i = 0; i < 60; i++) push_req(sgm_pkg::OP_PIXEL, pick_pixel());

    // A frame abandoned half way by a size change.
    setup(5, 4, 1'b1, 0, 0);
    for (int i = 0; i < 11; i++) push_req(sgm_pkg::OP_PIXEL, pick_pixel());

    // Receiver holds off while the sender keeps offering a full frame.
    setup(8, 6, 1'b1, 0, 0);
    push_frame(8, 6, 1'b0);
    @(negedge clk_i);
    hold_go = 1'b1;

    // Random frames through the idling mixes; small sizes dominate.
    stretch = 0;
    while (requests_taken + pixel_queue.size() < 800) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      case (stretch % 4)
        0: setup(w, h, 1'($urandom_range(1)), 0, 0);
        1: setup(w, h, 1'($urandom_range(1)), 73, 0);
        2: setup(w, h, 1'($urandom_range(1)), 0, 73);
        default: setup(w, h, 1'($urandom_range(1)), 31, 31);
      endcase
      for (int f = $urandom_range(1, 3); f > 0; f--)
        push_frame(w, h, $urandom_range(4) == 0);
      // Now and then a broken frame that the next size write abandons.
      if ($urandom_range(5) == 0)
        for (int i = $urandom_range(1, w * h); i > 0; i--)
          push_req(sgm_pkg::OP_PIXEL, pick_pixel());
      stretch++;
    end
    settle();

    $display("Run covered %0d frames, %0d requests and %0d checked magnitudes,",
             frames_sent, requests_taken, results_checked);
    $display("with both border modes, clamped and tiny sizes and idling mixes.");
    if (errors == 0 && magnitude_queue.size() == 0) begin
      $display("** sobel_gradient_magnitude_unit: PASSED **");
    end else begin
      $display("** sobel_gradient_magnitude_unit: FAILED **");
    end
    $finish;
  end

endmodule
